// File: design/gcce_pkg.sv
// Shared types and constants for the graph cycle check engine.
// No dependencies; used by gcce_ctrl, gcce_datapath and the top level.
package gcce_pkg;

    localparam int NODE_COUNT    = 64;
    localparam int EDGE_CAPACITY = 256;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int EIDX_W  = $clog2(EDGE_CAPACITY);
    localparam int LINK_W  = $clog2(EDGE_CAPACITY + 1);
    localparam int DEPTH_W = $clog2(NODE_COUNT + 1);

    // Empty list marker: one past the last edge slot.
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(EDGE_CAPACITY);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] src_node;
        logic [5:0] dst_node;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       cycle_found;
    } rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0] origin;
        logic [NODE_W-1:0] target;
        logic [LINK_W-1:0] link;
    } edge_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       clr_graph;
        logic       head_rd_src;
        logic       add_wr;
        logic       edge_rd_top;
        logic       rem_wr;
        logic       chk_init;
        logic       pop;
        logic       head_rd_node;
        logic       edge_rd_head;
        logic       edge_step;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_found;
        logic       out_load;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic stack_empty;
        logic head_has_edge;
        logic hit;
        logic link_has_edge;
        logic out_free;
    } sts_t;

endpackage

// File: design/gcce_ctrl.sv
// Sequencing state machine of the graph cycle check engine.
// Depends on gcce_pkg; drives gcce_datapath through ctl_t commands.
module gcce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        opcode,
    input  gcce_pkg::sts_t    sts,
    output gcce_pkg::ctl_t    ctl
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_ADD_RD    = 11'b000_0000_0010,
        S_ADD_WR    = 11'b000_0000_0100,
        S_REM_RD    = 11'b000_0000_1000,
        S_REM_WR    = 11'b000_0001_0000,
        S_CHK_INIT  = 11'b000_0010_0000,
        S_POP       = 11'b000_0100_0000,
        S_POP_WAIT  = 11'b000_1000_0000,
        S_HEAD_WAIT = 11'b001_0000_0000,
        S_EDGE_WAIT = 11'b010_0000_0000,
        S_RESP      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.load_in = 1'b1;
                    unique case (opcode)
                        gcce_pkg::OP_ADD:    state_next = S_ADD_RD;
                        gcce_pkg::OP_REMOVE: state_next = S_REM_RD;
                        gcce_pkg::OP_CHECK:  state_next = S_CHK_INIT;
                        default:
                        begin
                            ctl.clr_graph  = 1'b1;
                            ctl.res_set    = 1'b1;
                            ctl.res_status = gcce_pkg::ST_OK;
                            state_next     = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                if (sts.full)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = gcce_pkg::ST_FULL;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.head_rd_src = 1'b1;
                    state_next      = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                ctl.add_wr     = 1'b1;
                ctl.res_set    = 1'b1;
                ctl.res_status = gcce_pkg::ST_OK;
                state_next     = S_RESP;
            end
            S_REM_RD:
            begin
                if (sts.empty)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = gcce_pkg::ST_EMPTY;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.edge_rd_top = 1'b1;
                    state_next      = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                ctl.rem_wr     = 1'b1;
                ctl.res_set    = 1'b1;
                ctl.res_status = gcce_pkg::ST_OK;
                state_next     = S_RESP;
            end
            S_CHK_INIT:
            begin
                ctl.chk_init = 1'b1;
                state_next   = S_POP;
            end
            S_POP:
            begin
                if (sts.stack_empty)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = gcce_pkg::ST_OK;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.pop    = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                ctl.head_rd_node = 1'b1;
                state_next       = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                if (sts.head_has_edge)
                begin
                    ctl.edge_rd_head = 1'b1;
                    state_next       = S_EDGE_WAIT;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_EDGE_WAIT:
            begin
                if (sts.hit)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = gcce_pkg::ST_OK;
                    ctl.res_found  = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    // walk on to the next older edge of this node
                    ctl.edge_step = 1'b1;
                    state_next    = sts.link_has_edge ? S_EDGE_WAIT : S_POP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/gcce_datapath.sv
// Datapath of the graph cycle check engine: list heads, edge store,
// search stack, visited map and the result register. Depends on gcce_pkg.
module gcce_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  gcce_pkg::req_t    req,
    input  gcce_pkg::ctl_t    ctl,
    output gcce_pkg::sts_t    sts,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output gcce_pkg::rsp_t    rsp
);

    localparam int NODE_W  = gcce_pkg::NODE_W;
    localparam int EIDX_W  = gcce_pkg::EIDX_W;
    localparam int LINK_W  = gcce_pkg::LINK_W;
    localparam int DEPTH_W = gcce_pkg::DEPTH_W;

    // latched request
    logic [NODE_W-1:0]  src_reg;
    logic [NODE_W-1:0]  dst_reg;

    // list heads: memory plus per-node valid bits (invalid reads as null)
    logic [LINK_W-1:0]  head_mem [gcce_pkg::NODE_COUNT];
    logic [gcce_pkg::NODE_COUNT-1:0] head_vld_reg;
    logic [LINK_W-1:0]  head_q;
    logic               head_vq;
    logic [LINK_W-1:0]  head_eff;
    logic [NODE_W-1:0]  head_raddr;
    logic [NODE_W-1:0]  head_waddr;
    logic [LINK_W-1:0]  head_wdata;
    logic               head_we;

    // edge store
    gcce_pkg::edge_t    edge_mem [gcce_pkg::EDGE_CAPACITY];
    gcce_pkg::edge_t    edge_q;
    logic [EIDX_W-1:0]  edge_raddr;
    logic               edge_re;
    logic [LINK_W-1:0]  edge_total_reg;
    logic [LINK_W-1:0]  top_idx;

    // search stack and visited map
    logic [NODE_W-1:0]  stack_mem [gcce_pkg::NODE_COUNT];
    logic [NODE_W-1:0]  stack_q;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] pop_idx;
    logic [NODE_W-1:0]  stack_waddr;
    logic [NODE_W-1:0]  stack_wdata;
    logic               stack_we;
    logic [gcce_pkg::NODE_COUNT-1:0] seen_reg;
    logic               push;

    // result
    logic [1:0]         status_reg;
    logic               found_reg;
    logic               rsp_valid_reg;
    gcce_pkg::rsp_t     rsp_reg;

    assign top_idx  = edge_total_reg - LINK_W'(1);
    assign pop_idx  = depth_reg - DEPTH_W'(1);
    assign head_eff = head_vq ? head_q : gcce_pkg::LINK_NULL;

    assign push = ctl.edge_step && !seen_reg[edge_q.target]
                  && (depth_reg < DEPTH_W'(gcce_pkg::NODE_COUNT));

    always_comb
    begin
        sts.full          = (edge_total_reg == LINK_W'(gcce_pkg::EDGE_CAPACITY));
        sts.empty         = (edge_total_reg == '0);
        sts.stack_empty   = (depth_reg == '0);
        sts.head_has_edge = (head_eff < edge_total_reg);
        sts.hit           = (edge_q.target == dst_reg);
        sts.link_has_edge = (edge_q.link < edge_total_reg);
        sts.out_free      = !rsp_valid_reg || !rsp_stall;
    end

    // head port selection
    assign head_raddr = ctl.head_rd_src ? src_reg : stack_q;
    assign head_we    = ctl.add_wr || ctl.rem_wr;
    assign head_waddr = ctl.add_wr ? src_reg : edge_q.origin;
    assign head_wdata = ctl.add_wr ? edge_total_reg : edge_q.link;

    // edge read port selection
    assign edge_re = ctl.edge_rd_top || ctl.edge_rd_head || ctl.edge_step;
    always_comb
    begin
        if (ctl.edge_rd_top)
        begin
            edge_raddr = top_idx[EIDX_W-1:0];
        end
        else if (ctl.edge_rd_head)
        begin
            edge_raddr = head_eff[EIDX_W-1:0];
        end
        else
        begin
            edge_raddr = edge_q.link[EIDX_W-1:0];
        end
    end

    // stack write port selection
    assign stack_we    = ctl.chk_init || push;
    assign stack_waddr = ctl.chk_init ? '0 : depth_reg[NODE_W-1:0];
    assign stack_wdata = ctl.chk_init ? dst_reg : edge_q.target;

    // memories
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (ctl.head_rd_src || ctl.head_rd_node)
        begin
            head_q <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_wr)
        begin
            edge_mem[edge_total_reg[EIDX_W-1:0]] <= '{origin: src_reg,
                                                       target: dst_reg,
                                                       link:   head_eff};
        end
        if (edge_re)
        begin
            edge_q <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (ctl.pop)
        begin
            stack_q <= stack_mem[pop_idx[NODE_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            src_reg <= req.src_node;
            dst_reg <= req.dst_node;
        end
        if (ctl.head_rd_src || ctl.head_rd_node)
        begin
            head_vq <= head_vld_reg[head_raddr];
        end
        if (ctl.res_set)
        begin
            status_reg <= ctl.res_status;
            found_reg  <= ctl.res_found;
        end
        if (ctl.out_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.cycle_found <= found_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg   <= '0;
            edge_total_reg <= '0;
            depth_reg      <= '0;
            seen_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_graph)
            begin
                head_vld_reg   <= '0;
                edge_total_reg <= '0;
            end
            else
            begin
                if (head_we)
                begin
                    head_vld_reg[head_waddr] <= 1'b1;
                end
                if (ctl.add_wr)
                begin
                    edge_total_reg <= edge_total_reg + LINK_W'(1);
                end
                else if (ctl.rem_wr)
                begin
                    edge_total_reg <= top_idx;
                end
            end

            if (ctl.chk_init)
            begin
                depth_reg <= DEPTH_W'(1);
                // only the start node is marked
                seen_reg  <= {{(gcce_pkg::NODE_COUNT-1){1'b0}}, 1'b1} << dst_reg;
            end
            else if (ctl.pop)
            begin
                depth_reg <= pop_idx;
            end
            else if (push)
            begin
                depth_reg <= depth_reg + DEPTH_W'(1);
                seen_reg[edge_q.target] <= 1'b1;
            end

            if (ctl.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(gcce_pkg::NODE_COUNT))
        else $error("search stack depth beyond node count");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= LINK_W'(gcce_pkg::EDGE_CAPACITY))
        else $error("edge count beyond capacity");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.add_wr |-> !sts.full)
        else $error("edge written into a full store");

    a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> seen_reg[$past(edge_q.target)])
        else $error("pushed node not marked visited");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> sts.out_free)
        else $error("result overwritten while held");
`endif

endmodule

// File: design/graph_cycle_check_engine.sv
// Graph cycle check engine: directed graph in fixed tables with add, remove,
// clear and depth-first cycle check. Request channel req (valid/stall),
// response channel rsp (valid/stall); every request yields one response beat.
// From accept to rsp_valid: clear goes straight to the response load; add
// and remove do one list head or edge read, one write, then the response
// load, and skip the read and write when the store is full (add) or empty (remove).
// A check pushes the start node, then pops nodes from the search stack,
// reads the list head of each and walks its edges until a hit or an empty
// stack; the edge walk is one read of the edge store per cycle.
// One request is in work at a time: req_stall is high from the beat that is
// taken until the response is loaded into the output register.
// The output register holds a response while rsp_stall is high; the engine
// waits with its next response until that beat is taken, and it takes the
// next request while a response still sits there.
// Reset empties the graph (all lists null, edge count zero) and clears the
// visited map and stack depth; the edge store and stack contents are not
// cleared since only entries below the current counts are ever read.
// Depends on gcce_pkg, gcce_ctrl and gcce_datapath.
module graph_cycle_check_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  gcce_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output gcce_pkg::rsp_t    rsp
);

    gcce_pkg::ctl_t ctl;
    gcce_pkg::sts_t sts;

    gcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (req.opcode),
        .sts       (sts),
        .ctl       (ctl)
    );

    gcce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
